// File: hdl/bls_pkg.sv
// Shared widths, codes and item types for the Bresenham line stepper.
package bls_pkg;

   localparam int COORD_BITS = 12;
   localparam int DIST_BITS  = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   coord_ext_type;
   typedef logic [COORD_BITS-1:0]        span_type;
   typedef logic [DIST_BITS-1:0]         dist_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic signed [ERR_BITS:0]     err_ext_type;

   typedef enum logic [0:0] {
      FUNC_START   = 1'b0,
      FUNC_ADVANCE = 1'b1
   } func_type;

   typedef struct packed {
      func_type  func;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      dist_type  step_distance;
      dist_type  span_sum;
      logic      last;
   } rsp_type;

   typedef struct packed {
      coord_type current_x;
      coord_type current_y;
      coord_type target_x;
      coord_type target_y;
      span_type  span_x;
      span_type  span_y;
      logic      x_goes_down;
      logic      y_goes_down;
      err_type   error_term;
      dist_type  moves_done;
      logic      line_active;
   } line_state_type;

endpackage

// File: hdl/bls_step.sv
// Single-pass line setup and error update that yields the next state and pixel.
module bls_step (
   input  bls_pkg::req_type        req,
   input  bls_pkg::line_state_type state_cur,
   output bls_pkg::line_state_type state_next,
   output bls_pkg::rsp_type        rsp,
   output logic                    rsp_made
);
   import bls_pkg::*;

   coord_ext_type  dx;
   coord_ext_type  dy;
   coord_ext_type  abs_dx;
   coord_ext_type  abs_dy;
   span_type       new_span_x;
   span_type       new_span_y;
   err_ext_type    e2;
   err_ext_type    sx_ext;
   err_ext_type    sy_ext;
   err_ext_type    err_sum;
   logic           move_x;
   logic           move_y;
   logic           at_end;
   line_state_type st;

   // Setup for a new line.
   assign dx         = coord_ext_type'(req.end_x) - coord_ext_type'(req.start_x);
   assign dy         = coord_ext_type'(req.end_y) - coord_ext_type'(req.start_y);
   assign abs_dx     = dx[COORD_BITS] ? -dx : dx;
   assign abs_dy     = dy[COORD_BITS] ? -dy : dy;
   assign new_span_x = abs_dx[COORD_BITS-1:0];
   assign new_span_y = abs_dy[COORD_BITS-1:0];

   // One Bresenham error update on the active line.
   assign e2      = $signed({state_cur.error_term, 1'b0});
   assign sx_ext  = $signed({3'b000, state_cur.span_x});
   assign sy_ext  = $signed({3'b000, state_cur.span_y});
   assign move_x  = e2 > -sy_ext;
   assign move_y  = e2 < sx_ext;
   assign err_sum = err_ext_type'(state_cur.error_term)
                    - (move_x ? sy_ext : err_ext_type'(0))
                    + (move_y ? sx_ext : err_ext_type'(0));

   always_comb begin
      st       = state_cur;
      rsp_made = 1'b0;
      if (req.func == FUNC_START) begin
         st.current_x   = req.start_x;
         st.current_y   = req.start_y;
         st.target_x    = req.end_x;
         st.target_y    = req.end_y;
         st.span_x      = new_span_x;
         st.span_y      = new_span_y;
         st.x_goes_down = !(req.start_x < req.end_x);
         st.y_goes_down = !(req.start_y < req.end_y);
         st.error_term  = $signed({2'b00, new_span_x}) - $signed({2'b00, new_span_y});
         st.moves_done  = '0;
         rsp_made       = 1'b1;
      end else if (state_cur.line_active) begin
         if (move_x) begin
            st.current_x = state_cur.x_goes_down ? state_cur.current_x - coord_type'(1)
                                                 : state_cur.current_x + coord_type'(1);
         end
         if (move_y) begin
            st.current_y = state_cur.y_goes_down ? state_cur.current_y - coord_type'(1)
                                                 : state_cur.current_y + coord_type'(1);
         end
         st.error_term = err_sum[ERR_BITS-1:0];
         st.moves_done = state_cur.moves_done + dist_type'(move_x) + dist_type'(move_y);
         rsp_made      = 1'b1;
      end

      at_end = (st.current_x == st.target_x) && (st.current_y == st.target_y);

      rsp.pixel_x       = st.current_x;
      rsp.pixel_y       = st.current_y;
      rsp.step_distance = st.moves_done;
      rsp.span_sum      = dist_type'(st.span_x) + dist_type'(st.span_y);
      rsp.last          = at_end;

      state_next = st;
      if (rsp_made) begin
         state_next.line_active = !at_end;
      end
   end

endmodule

// File: hdl/bresenham_line_stepper_core.sv
// Top level of the all-octant Bresenham line stepper.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-----------------------------------
//   req     | in        | req_valid/req_stall  | func, start_x/y, end_x/y
//   rsp     | out       | rsp_valid/rsp_stall  | pixel_x/y, step_distance, span_sum, last
//
// The block takes one item per clock while req_stall is low; each pixel passes
// through the input register and then the result register after its item is accepted.
// The line state is updated by a single pass of the step logic, so a start or an
// advance item may follow the previous one back to back.
// Reset is synchronous and clears both registers' valid flags and the line state,
// leaving no line active. While rsp_stall is high the waiting result holds and the
// input register can still take one more item; req_stall rises only once both are full.
module bresenham_line_stepper_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bls_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bls_pkg::rsp_type rsp_data
);
   import bls_pkg::*;

   // Input register: holds one accepted item until the step logic can use it.
   logic           in_full_ff;
   logic           in_full_in;
   req_type        in_req_ff;

   // Line state, updated once per item that reaches the step logic.
   line_state_type state_ff;
   line_state_type state_in;

   // Result register.
   logic           out_full_ff;
   logic           out_full_in;
   rsp_type        out_rsp_ff;
   rsp_type        step_rsp;
   logic           step_made;

   logic           out_free;
   logic           step_go;
   logic           req_accept;

   bls_step u_step (
      .req        (in_req_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .rsp        (step_rsp),
      .rsp_made   (step_made)
   );

   // The step logic fires when an item is waiting and the result register is
   // empty or being emptied in this cycle.
   assign out_free   = !out_full_ff || !rsp_stall;
   assign step_go    = in_full_ff && out_free;
   assign req_stall  = in_full_ff && !step_go;
   assign req_accept = req_valid && !req_stall;

   assign in_full_in  = req_accept || (in_full_ff && !step_go);
   // An advance with no active line is consumed without a result.
   assign out_full_in = step_go ? step_made : (out_full_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_full_ff  <= 1'b0;
         out_full_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_full_ff  <= in_full_in;
         out_full_ff <= out_full_in;
         if (step_go) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_req_ff <= req_data;
      end
      if (step_go && step_made) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_full_ff;
   assign rsp_data  = out_rsp_ff;

   // The endpoint pixel closes the line.
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      step_go && step_made && step_rsp.last |=> !state_ff.line_active)
      else $error("line still active after its last pixel");

   // An advance with no active line leaves the result register empty.
   a_idle_advance_silent: assert property (@(posedge clock) disable iff (reset)
      step_go && (in_req_ff.func == FUNC_ADVANCE) && !state_ff.line_active |=> !rsp_valid)
      else $error("advance without a line produced a result");

   // The walk never covers more moves than the whole line has.
   a_step_within_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.step_distance <= rsp_data.span_sum)
      else $error("step distance exceeds total distance");

endmodule
